[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the steering force unit checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/sfu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering force unit package
// Behaviour codes, pipeline depths, the carried item record and helpers.
// ----------------------------------------------------------------------------
package sfu_pkg;

  localparam logic [2:0] FUNC_SEEK   = 3'd0;
  localparam logic [2:0] FUNC_FLEE   = 3'd1;
  localparam logic [2:0] FUNC_ARRIVE = 3'd2;
  localparam logic [2:0] FUNC_PURSUE = 3'd3;
  localparam logic [2:0] FUNC_EVADE  = 3'd4;

  // One root bit per square-root stage, one quotient bit per divider stage
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 32;

  localparam logic [30:0] ARRIVE_RADIUS_RST = 31'd655360;

  // Squared raw offset below which arrive counts as already there
  localparam logic [6:0] ARRIVE_EPS_SQ = 7'd43;
  localparam logic [32:0] NEAR_AXIS    = 33'd7;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tvx;
    logic signed [31:0] tvy;
    logic [30:0]        speed;
    logic [30:0]        fmax;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic               nx;
    logic               ny;
    logic [32:0]        len;
    logic               ovf;
    logic               near;
    logic               slow;
    logic               lim;
    logic [30:0]        sp;
    logic signed [33:0] sx;
    logic signed [33:0] sy;
  } item_t;

  function automatic logic [32:0] abs34(input logic signed [33:0] v);
    logic signed [33:0] m;
    begin
      m = v[33] ? -v : v;
      return m[32:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    begin
      if (v > 50'sd2147483647) begin
        return 32'sh7fffffff;
      end else if (v < -50'sd2147483648) begin
        return 32'sh80000000;
      end
      return v[31:0];
    end
  endfunction

endpackage

[rtl/core/sfu_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// floor(sqrt) of a 66-bit radicand, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module sfu_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [65:0] rad,
  output logic [32:0] root
);

  logic [65:0] rad_q  [sfu_pkg::SQRT_STEPS];
  logic [35:0] rem_q  [sfu_pkg::SQRT_STEPS];
  logic [32:0] root_q [sfu_pkg::SQRT_STEPS];

  for (genvar g = 0; g < sfu_pkg::SQRT_STEPS; g++) begin : g_stage
    logic [65:0] rad_in;
    logic [35:0] rem_in;
    logic [32:0] root_in;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    if (g == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    // bring down the next bit pair and try root*4+1
    assign rem_sh = {rem_in[33:0], rad_in[65:64]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[g]  <= {rad_in[63:0], 2'b00};
        rem_q[g]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[g] <= {root_in[31:0], ge};
      end
    end
  end

  assign root = root_q[sfu_pkg::SQRT_STEPS-1];

endmodule

[rtl/core/sfu_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// 64-bit dividend over 33-bit divisor, 32-bit quotient, one bit per stage.
// ----------------------------------------------------------------------------
module sfu_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output logic [31:0] quo
);

  logic [63:0] rem_q [sfu_pkg::DIV_STEPS];
  logic [32:0] den_q [sfu_pkg::DIV_STEPS];
  logic [31:0] quo_q [sfu_pkg::DIV_STEPS];

  for (genvar g = 0; g < sfu_pkg::DIV_STEPS; g++) begin : g_stage
    localparam int SH = sfu_pkg::DIV_STEPS - 1 - g;
    logic [63:0] rem_in;
    logic [32:0] den_in;
    logic [31:0] quo_in;
    logic [64:0] dsh;
    logic        ge;

    if (g == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    // trial subtract of the divisor aligned to this quotient bit
    assign dsh = {32'b0, den_in} << SH;
    assign ge  = ({1'b0, rem_in} >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g] <= ge ? (rem_in - dsh[63:0]) : rem_in;
        den_q[g] <= den_in;
        quo_q[g] <= {quo_in[30:0], ge};
      end
    end
  end

  assign quo = quo_q[sfu_pkg::DIV_STEPS-1];

endmodule

[rtl/core/steering_force_unit.sv]
`timescale 1ns / 1ps
// Throughput: one beat per cycle; three 33-stage root pipes and four 32-stage
//   divider pipes set the depth, and the whole pipe holds while out is stalled.
// Reset: clears every valid bit and loads the arrive radius with 10.0 (655360).
// ----------------------------------------------------------------------------
// Steering force unit
// Seek, flee, arrive, pursue and evade steering force in Q16.16.
// ----------------------------------------------------------------------------
module steering_force_unit (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel: slow radius
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_data,
  // input beat
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_vel_x,
  input  logic signed [31:0] target_vel_y,
  input  logic [30:0]        speed_limit,
  input  logic [30:0]        force_limit,
  // result beat
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y
);

  localparam int SQ = sfu_pkg::SQRT_STEPS;
  localparam int DV = sfu_pkg::DIV_STEPS;

  logic [30:0] arrive_radius;
  logic        adv;
  logic [17:0] v;

  sfu_pkg::item_t s0, s1, s2, s3, s4, s5, s6, s7, s8, s9;
  sfu_pkg::item_t s10, s11, s12, s13, s14, s15, s16;

  // side delay lines that run beside the root and divider pipes
  sfu_pkg::item_t dl1 [SQ];
  sfu_pkg::item_t dl2 [DV];
  sfu_pkg::item_t dl3 [SQ];
  sfu_pkg::item_t dl4 [DV];
  sfu_pkg::item_t dl5 [DV];
  sfu_pkg::item_t dl6 [SQ];
  sfu_pkg::item_t dl7 [DV];
  logic [SQ-1:0] dlv1, dlv3, dlv6;
  logic [DV-1:0] dlv2, dlv4, dlv5, dlv7;

  logic [65:0] sq1_a, sq1_b, rad1;
  logic [65:0] sq2_a, sq2_b, rad2;
  logic [65:0] sq3_a, sq3_b, rad3;
  logic [63:0] num_t, num_a, num_x, num_y, num_fx, num_fy;
  logic [32:0] den_t, den_a;
  logic [63:0] pm_x, pm_y;
  logic [32:0] root1, root2, root3;
  logic [31:0] quo1, quo2, quo3, quo4, quo5, quo6;

  // ---------------------------------------------------------------------------
  // Flow control: every stage moves together; hold all of it only while a
  // finished result waits on the output register.
  // ---------------------------------------------------------------------------
  assign adv       = !v[17] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v[17];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      arrive_radius <= sfu_pkg::ARRIVE_RADIUS_RST;
    end else if (cfg_valid) begin
      arrive_radius <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits, travelling with the data
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      dlv1 <= '0;
      dlv2 <= '0;
      dlv3 <= '0;
      dlv4 <= '0;
      dlv5 <= '0;
      dlv6 <= '0;
      dlv7 <= '0;
    end else if (adv) begin
      v[0]  <= in_valid;
      v[1]  <= v[0];
      v[2]  <= v[1];
      v[3]  <= v[2];
      dlv1  <= {dlv1[SQ-2:0], v[3]};
      v[4]  <= dlv1[SQ-1];
      dlv2  <= {dlv2[DV-2:0], v[4]};
      v[5]  <= dlv2[DV-1];
      v[6]  <= v[5];
      v[7]  <= v[6];
      v[8]  <= v[7];
      v[9]  <= v[8];
      dlv3  <= {dlv3[SQ-2:0], v[9]};
      v[10] <= dlv3[SQ-1];
      dlv4  <= {dlv4[DV-2:0], v[10]};
      v[11] <= dlv4[DV-1];
      dlv5  <= {dlv5[DV-2:0], v[11]};
      v[12] <= dlv5[DV-1];
      v[13] <= v[12];
      v[14] <= v[13];
      v[15] <= v[14];
      dlv6  <= {dlv6[SQ-2:0], v[15]};
      v[16] <= dlv6[SQ-1];
      dlv7  <= {dlv7[DV-2:0], v[16]};
      v[17] <= dlv7[DV-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Side delay lines: advance in step with the arithmetic pipes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      dl1[0] <= s3;
      dl3[0] <= s9;
      dl6[0] <= s15;
      for (int i = 1; i < SQ; i++) begin
        dl1[i] <= dl1[i-1];
        dl3[i] <= dl3[i-1];
        dl6[i] <= dl6[i-1];
      end
      dl2[0] <= s4;
      dl4[0] <= s10;
      dl5[0] <= s11;
      dl7[0] <= s16;
      for (int i = 1; i < DV; i++) begin
        dl2[i] <= dl2[i-1];
        dl4[i] <= dl4[i-1];
        dl5[i] <= dl5[i-1];
        dl7[i] <= dl7[i-1];
      end
    end
  end

  // square of the low three bits, only meaningful when the axis is below 8
  function automatic logic [5:0] s7_sq(input logic signed [32:0] d);
    logic [32:0] m;
    begin
      m = sfu_pkg::abs34({d[32], d});
      return 6'(m[2:0]) * 6'(m[2:0]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Combinational pieces of the main stages
  // ---------------------------------------------------------------------------
  logic signed [32:0] pdx, pdy, mdx, mdy;
  logic               away;
  logic [31:0]        t5;
  logic [47:0]        off_x, off_y;
  logic signed [49:0] ptx, pty;
  logic [6:0]         near_sq;
  logic [30:0]        sp11;
  logic signed [33:0] wx, wy;
  logic signed [31:0] fx_lim, fy_lim;

  always_comb begin
    // offset to the target for the prediction distance
    pdx = {s0.tx[31], s0.tx} - {s0.px[31], s0.px};
    pdy = {s0.ty[31], s0.ty} - {s0.py[31], s0.py};

    // prediction time, saturated when the speed cannot cover the distance
    t5 = dl2[DV-1].ovf ? '1 : quo1;

    // predicted target position
    off_x = pm_x[63:16];
    off_y = pm_y[63:16];
    ptx = {{18{s5.tx[31]}}, s5.tx}
        + (s5.tvx[31] ? -$signed({2'b0, off_x}) : $signed({2'b0, off_x}));
    pty = {{18{s5.ty[31]}}, s5.ty}
        + (s5.tvy[31] ? -$signed({2'b0, off_y}) : $signed({2'b0, off_y}));

    // steering offset: away from the target for flee and evade
    away = (s6.func == sfu_pkg::FUNC_FLEE) || (s6.func == sfu_pkg::FUNC_EVADE);
    mdx  = away ? ({s6.px[31], s6.px} - {s6.tx[31], s6.tx})
                : ({s6.tx[31], s6.tx} - {s6.px[31], s6.px});
    mdy  = away ? ({s6.py[31], s6.py} - {s6.ty[31], s6.ty})
                : ({s6.ty[31], s6.ty} - {s6.py[31], s6.py});
    near_sq = 7'(s7_sq(mdx)) + 7'(s7_sq(mdy));

    // arrive slows down inside the radius
    sp11 = ((dl4[DV-1].func == sfu_pkg::FUNC_ARRIVE) && dl4[DV-1].slow)
         ? quo2[30:0] : dl4[DV-1].speed;

    // desired velocity; a zero offset gives none
    if (dl5[DV-1].len == '0) begin
      wx = '0;
      wy = '0;
    end else begin
      wx = dl5[DV-1].nx ? -$signed({2'b0, quo3}) : $signed({2'b0, quo3});
      wy = dl5[DV-1].ny ? -$signed({2'b0, quo4}) : $signed({2'b0, quo4});
    end

    // scaled force when over the limit
    fx_lim = dl7[DV-1].nx ? -$signed({1'b0, quo5[30:0]}) : $signed({1'b0, quo5[30:0]});
    fy_lim = dl7[DV-1].ny ? -$signed({1'b0, quo6[30:0]}) : $signed({1'b0, quo6[30:0]});
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      // input register
      s0       <= '0;
      s0.func  <= func;
      s0.px    <= pos_x;
      s0.py    <= pos_y;
      s0.vx    <= vel_x;
      s0.vy    <= vel_y;
      s0.tx    <= target_x;
      s0.ty    <= target_y;
      s0.tvx   <= target_vel_x;
      s0.tvy   <= target_vel_y;
      s0.speed <= speed_limit;
      s0.fmax  <= force_limit;

      // prediction distance
      s1    <= s0;
      s1.ax <= sfu_pkg::abs34({pdx[32], pdx});
      s1.ay <= sfu_pkg::abs34({pdy[32], pdy});
      s2    <= s1;
      sq1_a <= 66'(s1.ax) * 66'(s1.ax);
      sq1_b <= 66'(s1.ay) * 66'(s1.ay);
      s3    <= s2;
      rad1  <= sq1_a + sq1_b;

      // prediction time = dist / speed in Q16.16
      s4     <= dl1[SQ-1];
      s4.len <= root1;
      s4.ovf <= (dl1[SQ-1].speed == '0) ||
                ({14'b0, root1} >= {dl1[SQ-1].speed, 16'b0});
      num_t  <= {15'b0, root1, 16'b0};
      den_t  <= {2'b0, dl1[SQ-1].speed};

      s5   <= dl2[DV-1];
      pm_x <= 64'(sfu_pkg::abs34({{2{dl2[DV-1].tvx[31]}}, dl2[DV-1].tvx})) * 64'(t5);
      pm_y <= 64'(sfu_pkg::abs34({{2{dl2[DV-1].tvy[31]}}, dl2[DV-1].tvy})) * 64'(t5);

      s6 <= s5;
      if ((s5.func == sfu_pkg::FUNC_PURSUE) || (s5.func == sfu_pkg::FUNC_EVADE)) begin
        s6.tx <= sfu_pkg::sat32(ptx);
        s6.ty <= sfu_pkg::sat32(pty);
      end

      // steering offset and its length
      s7      <= s6;
      s7.ax   <= sfu_pkg::abs34({mdx[32], mdx});
      s7.ay   <= sfu_pkg::abs34({mdy[32], mdy});
      s7.nx   <= mdx[32];
      s7.ny   <= mdy[32];
      s7.near <= (sfu_pkg::abs34({mdx[32], mdx}) < sfu_pkg::NEAR_AXIS) &&
                 (sfu_pkg::abs34({mdy[32], mdy}) < sfu_pkg::NEAR_AXIS) &&
                 (near_sq < sfu_pkg::ARRIVE_EPS_SQ);
      s8    <= s7;
      sq2_a <= 66'(s7.ax) * 66'(s7.ax);
      sq2_b <= 66'(s7.ay) * 66'(s7.ay);
      s9    <= s8;
      rad2  <= sq2_a + sq2_b;

      // arrive speed = speed * dist / radius
      s10      <= dl3[SQ-1];
      s10.len  <= root2;
      s10.slow <= (root2 < {2'b0, arrive_radius});
      num_a    <= 64'(dl3[SQ-1].speed) * 64'(root2[30:0]);
      den_a    <= {2'b0, arrive_radius};

      // desired velocity = offset * speed / len
      s11    <= dl4[DV-1];
      s11.sp <= sp11;
      num_x  <= 64'(dl4[DV-1].ax) * 64'(sp11);
      num_y  <= 64'(dl4[DV-1].ay) * 64'(sp11);

      // raw steering = desired - velocity
      s12    <= dl5[DV-1];
      s12.sx <= wx - {{2{dl5[DV-1].vx[31]}}, dl5[DV-1].vx};
      s12.sy <= wy - {{2{dl5[DV-1].vy[31]}}, dl5[DV-1].vy};

      s13    <= s12;
      s13.ax <= sfu_pkg::abs34(s12.sx);
      s13.ay <= sfu_pkg::abs34(s12.sy);
      s13.nx <= s12.sx[33];
      s13.ny <= s12.sy[33];
      s14    <= s13;
      sq3_a  <= 66'(s13.ax) * 66'(s13.ax);
      sq3_b  <= 66'(s13.ay) * 66'(s13.ay);
      s15    <= s14;
      rad3   <= sq3_a + sq3_b;

      // truncate to the force limit
      s16     <= dl6[SQ-1];
      s16.len <= root3;
      s16.lim <= (root3 > {2'b0, dl6[SQ-1].fmax});
      num_fx  <= 64'(dl6[SQ-1].ax) * 64'(dl6[SQ-1].fmax);
      num_fy  <= 64'(dl6[SQ-1].ay) * 64'(dl6[SQ-1].fmax);

      // output register
      if (dl7[DV-1].func > sfu_pkg::FUNC_EVADE) begin
        force_x <= '0;
        force_y <= '0;
      end else if ((dl7[DV-1].func == sfu_pkg::FUNC_ARRIVE) && dl7[DV-1].near) begin
        force_x <= sfu_pkg::sat32(-{{18{dl7[DV-1].vx[31]}}, dl7[DV-1].vx});
        force_y <= sfu_pkg::sat32(-{{18{dl7[DV-1].vy[31]}}, dl7[DV-1].vy});
      end else if (dl7[DV-1].lim) begin
        force_x <= fx_lim;
        force_y <= fy_lim;
      end else begin
        force_x <= sfu_pkg::sat32({{16{dl7[DV-1].sx[33]}}, dl7[DV-1].sx});
        force_y <= sfu_pkg::sat32({{16{dl7[DV-1].sy[33]}}, dl7[DV-1].sy});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Root and divider pipes
  // ---------------------------------------------------------------------------
  sfu_sqrt u_sqrt_dist (.clk(clk), .en(adv), .rad(rad1), .root(root1));
  sfu_div  u_div_time  (.clk(clk), .en(adv), .num(num_t), .den(den_t), .quo(quo1));
  sfu_sqrt u_sqrt_off  (.clk(clk), .en(adv), .rad(rad2), .root(root2));
  sfu_div  u_div_slow  (.clk(clk), .en(adv), .num(num_a), .den(den_a), .quo(quo2));
  sfu_div  u_div_wx    (.clk(clk), .en(adv), .num(num_x), .den(s11.len), .quo(quo3));
  sfu_div  u_div_wy    (.clk(clk), .en(adv), .num(num_y), .den(s11.len), .quo(quo4));
  sfu_sqrt u_sqrt_frc  (.clk(clk), .en(adv), .rad(rad3), .root(root3));
  sfu_div  u_div_fx    (.clk(clk), .en(adv), .num(num_fx), .den(s16.len), .quo(quo5));
  sfu_div  u_div_fy    (.clk(clk), .en(adv), .num(num_fy), .den(s16.len), .quo(quo6));

endmodule

[rtl/core/sfu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering force unit port checker
// Watches the top-level ports for flow-control and reset behaviour.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfu_checker (
  input logic               clk,
  input logic               rst,
  input logic               cfg_ready,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] force_x,
  input logic signed [31:0] force_y
);

  // a stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(force_x) && $stable(force_y), "stalled result beat changed")

  // input side stalls exactly when a result waits
  `ASSERT_IMPL(a_in_ready, clk, rst, 1'b1, in_ready == (!out_valid || out_ready), "in_ready does not follow output stall")

  // nothing comes out straight after reset
  `ASSERT_IMPL(a_rst_empty, clk, rst, $past(rst), !out_valid, "result beat right after reset")

  // configuration writes are never refused
  `ASSERT_IMPL(a_cfg_ready, clk, rst, 1'b1, cfg_ready, "cfg_ready dropped")

endmodule

bind steering_force_unit sfu_checker u_sfu_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg_ready),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .force_x   (force_x),
  .force_y   (force_y)
);
